// File: rtl/rac_pkg.sv
// Package for the rational accumulator ALU: transfer structs, command and
// status codes, sequencer states and the default accumulator width.
// No dependencies.
`default_nettype none
package rac_pkg;

    localparam int WIDTH_DEF = 32;

    localparam logic [2:0] CMD_LOAD = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_SUB  = 3'd2;
    localparam logic [2:0] CMD_MUL  = 3'd3;
    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_CMP  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] operand_num;
        logic signed [31:0] operand_den;
    } op_t;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
        logic               equal;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_ZCHK,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_CHECK,
        S_FIN,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// File: rtl/rational_accumulator_alu.sv
// Rational accumulator ALU: sequencer with one shared multiplier, a binary
// gcd loop and one shared restoring divider. Depends on rac_pkg.
`default_nettype none
//  channel | direction | handshake        | payload
//  op      | in        | op_valid/op_stall | rac_pkg::op_t
//  res     | out       | res_valid/res_stall | rac_pkg::res_t
//
// After acceptance a command passes through up to three multiplies and a sum,
// a binary gcd of one subtract or shift per cycle and two 64-bit restoring
// divisions; an unused command goes straight to the result.
// A zero denominator skips gcd and divides.
// op_stall is high from acceptance until the result transfer completes.
// Reset (rst_n low, asynchronous) sets the accumulator to 0/1.
module rational_accumulator_alu #(
    parameter int WIDTH = rac_pkg::WIDTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    output logic               op_stall,
    input  wire rac_pkg::op_t  op,
    output logic               res_valid,
    input  wire logic          res_stall,
    output rac_pkg::res_t      res
);
    import rac_pkg::*;

    localparam logic [63:0] LIM = 64'(1) << (WIDTH - 1);

    state_t      state_reg, state_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [31:0] bn_reg, bn_next;
    logic [31:0] bd_reg, bd_next;
    logic [1:0]  step_reg, step_next;
    logic        neg_reg, neg_next;
    logic [63:0] nm_reg, nm_next;
    logic [63:0] qm_reg, qm_next;
    logic [63:0] dm_reg, dm_next;
    logic [63:0] ga_reg, ga_next;
    logic [63:0] gb_reg, gb_next;
    logic [5:0]  gk_reg, gk_next;
    logic [63:0] g_reg, g_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] acc_num_reg, acc_num_next;
    logic [30:0] acc_den_reg, acc_den_next;
    logic [1:0]  status_reg, status_next;
    logic        equal_reg, equal_next;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg, res_next;

    logic [31:0] bn_mag, bd_mag, an_mag, den_mag;
    logic [31:0] mult_a, mult_b;
    logic [63:0] prod;
    logic        pn, qn;
    logic [64:0] div_t, div_diff;
    logic        div_ge;
    logic [63:0] rem_step, quo_step;
    logic        neg_eff, ovf;

    assign bn_mag  = bn_reg[31] ? (~bn_reg + 32'd1) : bn_reg;
    assign bd_mag  = bd_reg[31] ? (~bd_reg + 32'd1) : bd_reg;
    assign an_mag  = acc_num_reg[31] ? (~acc_num_reg + 32'd1) : acc_num_reg;
    assign den_mag = {1'b0, acc_den_reg};

    // Shared multiplier: operand pair chosen by the product step.
    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                mult_a = an_mag;
                mult_b = (cmd_reg == CMD_MUL) ? bn_mag : bd_mag;
            end
            2'd1:
            begin
                mult_a = den_mag;
                mult_b = bn_mag;
            end
            default:
            begin
                mult_a = den_mag;
                mult_b = (cmd_reg == CMD_DIV) ? bn_mag : bd_mag;
            end
        endcase
    end

    assign prod = 64'(mult_a) * 64'(mult_b);

    // Shared restoring divider step, one quotient bit per cycle.
    assign div_t    = {rem_reg, quo_reg[63]};
    assign div_ge   = div_t >= {1'b0, g_reg};
    assign div_diff = div_t - {1'b0, g_reg};
    assign rem_step = div_ge ? div_diff[63:0] : div_t[63:0];
    assign quo_step = {quo_reg[62:0], div_ge};

    assign pn = acc_num_reg[31] ^ bd_reg[31];
    assign qn = bn_reg[31] ^ (cmd_reg == CMD_SUB);

    assign neg_eff = neg_reg & (nm_reg != 64'd0);
    assign ovf     = (dm_reg > LIM - 64'd1) ||
                     (nm_reg > (neg_eff ? LIM : LIM - 64'd1));

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        bn_next        = bn_reg;
        bd_next        = bd_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        nm_next        = nm_reg;
        qm_next        = qm_reg;
        dm_next        = dm_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        gk_next        = gk_reg;
        g_next         = g_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        status_next    = status_reg;
        equal_next     = equal_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    cmd_next    = op.cmd;
                    bn_next     = op.operand_num;
                    bd_next     = op.operand_den;
                    step_next   = 2'd0;
                    status_next = ST_OK;
                    equal_next  = 1'b0;
                    neg_next    = op.operand_num[31] ^ op.operand_den[31];
                    nm_next     = 64'(op.operand_num[31] ?
                                      (~op.operand_num + 32'sd1) : op.operand_num);
                    dm_next     = 64'(op.operand_den[31] ?
                                      (~op.operand_den + 32'sd1) : op.operand_den);
                    nm_next[63:32] = 32'd0;
                    dm_next[63:32] = 32'd0;
                    case (op.cmd)
                        CMD_LOAD, CMD_CMP:               state_next = S_ZCHK;
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: state_next = S_MUL;
                        default:                         state_next = S_FIN;
                    endcase
                end
            end
            S_MUL:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        nm_next   = prod;
                        neg_next  = acc_num_reg[31] ^ bn_reg[31] ^ bd_reg[31];
                        step_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ?
                                    2'd1 : 2'd2;
                    end
                    2'd1:
                    begin
                        qm_next   = prod;
                        step_next = 2'd2;
                    end
                    default:
                    begin
                        dm_next    = prod;
                        state_next = (cmd_reg == CMD_ADD || cmd_reg == CMD_SUB) ?
                                     S_SUM : S_ZCHK;
                    end
                endcase
            end
            S_SUM:
            begin
                // Sign-magnitude sum; the sign moves over when bd is negative.
                if (pn == qn)
                begin
                    nm_next  = nm_reg + qm_reg;
                    neg_next = pn ^ bd_reg[31];
                end
                else if (nm_reg >= qm_reg)
                begin
                    nm_next  = nm_reg - qm_reg;
                    neg_next = pn ^ bd_reg[31];
                end
                else
                begin
                    nm_next  = qm_reg - nm_reg;
                    neg_next = qn ^ bd_reg[31];
                end
                state_next = S_ZCHK;
            end
            S_ZCHK:
            begin
                if (dm_reg == 64'd0)
                begin
                    status_next = ST_ZERO_DEN;
                    state_next  = S_FIN;
                end
                else
                begin
                    ga_next    = nm_reg;
                    gb_next    = dm_reg;
                    gk_next    = 6'd0;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                // Binary gcd; gb never reaches zero, the loop ends when ga does.
                if (ga_reg == 64'd0)
                begin
                    g_next     = gb_reg << gk_reg;
                    rem_next   = 64'd0;
                    quo_next   = nm_reg;
                    cnt_next   = 6'd0;
                    state_next = S_DIVN;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    gk_next = gk_reg + 6'd1;
                end
                else if (!ga_reg[0])
                begin
                    ga_next = ga_reg >> 1;
                end
                else if (!gb_reg[0])
                begin
                    gb_next = gb_reg >> 1;
                end
                else if (ga_reg >= gb_reg)
                begin
                    ga_next = ga_reg - gb_reg;
                end
                else
                begin
                    gb_next = gb_reg - ga_reg;
                end
            end
            S_DIVN:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    nm_next    = quo_step;
                    rem_next   = 64'd0;
                    quo_next   = dm_reg;
                    cnt_next   = 6'd0;
                    state_next = S_DIVD;
                end
            end
            S_DIVD:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    dm_next    = quo_step;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (cmd_reg == CMD_CMP)
                begin
                    equal_next = (neg_eff == acc_num_reg[31]) &&
                                 (nm_reg == 64'(an_mag)) &&
                                 (dm_reg == 64'(acc_den_reg));
                end
                else if (ovf)
                begin
                    status_next = ST_OVERFLOW;
                end
                else
                begin
                    acc_num_next = neg_eff ? (~nm_reg[31:0] + 32'd1) : nm_reg[31:0];
                    acc_den_next = dm_reg[30:0];
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next.result_num = acc_num_reg;
                res_next.result_den = acc_den_reg;
                res_next.status     = status_reg;
                res_next.equal      = equal_reg;
                res_valid_next      = 1'b1;
                state_next          = S_OUT;
            end
            S_OUT:
            begin
                if (!res_stall)
                begin
                    res_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_num_reg   <= 32'd0;
            acc_den_reg   <= 31'd1;
            res_valid_reg <= 1'b0;
            step_reg      <= 2'd0;
            cnt_reg       <= 6'd0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            res_valid_reg <= res_valid_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        bn_reg     <= bn_next;
        bd_reg     <= bd_next;
        neg_reg    <= neg_next;
        nm_reg     <= nm_next;
        qm_reg     <= qm_next;
        dm_reg     <= dm_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        gk_reg     <= gk_next;
        g_reg      <= g_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        status_reg <= status_next;
        equal_reg  <= equal_next;
        res_reg    <= res_next;
    end

    assign op_stall  = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire
